// ===== src/http_header_line_tokenizer_macros.svh =====
// Assertion macros for the HTTP header line tokenizer.
`ifndef HTTP_HEADER_LINE_TOKENIZER_MACROS_SVH
`define HTTP_HEADER_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HHLT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define HHLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== src/hhlt_pkg.sv =====
// Shared types and constants for the HTTP header line tokenizer.
package hhlt_pkg;

  localparam int LimitW = 12;
  localparam int OffW   = 13;

  localparam logic [LimitW-1:0] LIMIT_RESET = 12'd255;
  localparam logic [OffW-1:0]   OFFSET_MAX  = 13'h1FFF;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_DONE   = 4'd8,
    ST_ERROR  = 4'd9
  } state_e;

  typedef enum logic [2:0] {
    CLS_SEP   = 3'd0,
    CLS_KEY   = 3'd1,
    CLS_VALUE = 3'd2,
    CLS_LINE  = 3'd3,
    CLS_END   = 3'd4,
    CLS_ERROR = 3'd5,
    CLS_AFTER = 3'd6
  } cls_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } beat_t;

  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       first;
  } result_t;

endpackage

// ===== src/http_header_line_tokenizer.sv =====
// Top level of the HTTP header line tokenizer.
// An accepted byte waits in the input register; the parser state advances as it enters the result
// register. Throughput: one byte per cycle while out_stall_i is low.
// Reset: rst_ni clears the parser to start state, the value offset to zero,
// the value limit to 255 and both pipeline stages to empty.
module http_header_line_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [hhlt_pkg::LimitW-1:0] cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  byte_in_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  byte_out_o,
  output logic [2:0]                  token_class_o,
  output logic                        token_first_o
);

  `include "http_header_line_tokenizer_macros.svh"

  logic              pend;
  logic              adv;
  hhlt_pkg::beat_t   beat;
  hhlt_pkg::result_t res_d;
  hhlt_pkg::result_t res_q;

  hhlt_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .restart_i  (restart_i),
    .adv_i      (adv),
    .pend_o     (pend),
    .beat_o     (beat)
  );

  hhlt_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .adv_i         (adv),
    .beat_i        (beat),
    .res_o         (res_d)
  );

  hhlt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pend_i      (pend),
    .adv_o       (adv),
    .res_i       (res_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign byte_out_o    = res_q.data;
  assign token_class_o = res_q.cls;
  assign token_first_o = res_q.first;

  `HHLT_ASSERT_SAME(a_first_on_token,
    out_valid_o && token_first_o,
    token_class_o == hhlt_pkg::CLS_KEY || token_class_o == hhlt_pkg::CLS_VALUE)
  `HHLT_ASSERT_SAME(a_no_stall_when_empty, !out_valid_o, !in_stall_o)
  `HHLT_ASSERT_NEXT(a_stall_keeps_result, in_stall_o, out_valid_o)

endmodule

// ===== src/hhlt_in_stage.sv =====
// Input register stage: holds one accepted beat until the parser takes it.
module hhlt_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     byte_in_i,
  input  logic           restart_i,
  input  logic           adv_i,
  output logic           pend_o,
  output hhlt_pkg::beat_t beat_o
);

  logic            valid_q, valid_d;
  logic            accept;
  hhlt_pkg::beat_t beat_q;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.data    <= byte_in_i;
      beat_q.restart <= restart_i;
    end
  end

  assign pend_o = valid_q;
  assign beat_o = beat_q;

endmodule

// ===== src/hhlt_fsm.sv =====
// Parser state machine, value offset counter and value length limit register.
module hhlt_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [hhlt_pkg::LimitW-1:0] cfg_wr_data_i,
  input  logic                        adv_i,
  input  hhlt_pkg::beat_t             beat_i,
  output hhlt_pkg::result_t           res_o
);

  hhlt_pkg::state_e              state_q, state_d, cur_state;
  logic [hhlt_pkg::OffW-1:0]     off_q, off_d, off_inc;
  logic [hhlt_pkg::LimitW-1:0]   limit_q;
  logic [7:0]                    b;
  logic                          is_crlf;
  logic                          over;

  assign b         = beat_i.data;
  assign cur_state = beat_i.restart ? hhlt_pkg::ST_START : state_q;
  assign is_crlf   = (b == hhlt_pkg::CH_CR) || (b == hhlt_pkg::CH_LF);
  assign off_inc   = (off_q == hhlt_pkg::OFFSET_MAX) ? off_q : off_q + 1'b1;
  assign over      = off_inc > {1'b0, limit_q};

  // next state
  always_comb begin
    state_d = cur_state;
    off_d   = beat_i.restart ? '0 : off_q;
    unique case (cur_state)
      hhlt_pkg::ST_START: begin
        if (!is_crlf) state_d = hhlt_pkg::ST_KEY;
      end
      hhlt_pkg::ST_KEY: begin
        if (b == hhlt_pkg::CH_COLON) begin
          state_d = hhlt_pkg::ST_COLON;
        end else if (is_crlf) begin
          state_d = hhlt_pkg::ST_ERROR;
        end
      end
      hhlt_pkg::ST_COLON: begin
        state_d = (b == hhlt_pkg::CH_SPACE) ? hhlt_pkg::ST_SPACE : hhlt_pkg::ST_ERROR;
      end
      hhlt_pkg::ST_SPACE: begin
        state_d = hhlt_pkg::ST_VALUE;
        off_d   = '0;
      end
      hhlt_pkg::ST_VALUE: begin
        off_d = off_inc;
        if (b == hhlt_pkg::CH_CR) begin
          state_d = hhlt_pkg::ST_CR;
        end else if (over) begin
          state_d = hhlt_pkg::ST_ERROR;
        end
      end
      hhlt_pkg::ST_CR: begin
        state_d = (b == hhlt_pkg::CH_LF) ? hhlt_pkg::ST_LF : hhlt_pkg::ST_ERROR;
      end
      hhlt_pkg::ST_LF: begin
        state_d = (b == hhlt_pkg::CH_CR) ? hhlt_pkg::ST_END_CR : hhlt_pkg::ST_KEY;
      end
      hhlt_pkg::ST_END_CR: begin
        state_d = (b == hhlt_pkg::CH_LF) ? hhlt_pkg::ST_DONE : hhlt_pkg::ST_ERROR;
      end
      hhlt_pkg::ST_DONE: begin
        state_d = hhlt_pkg::ST_DONE;
      end
      default: begin
        state_d = hhlt_pkg::ST_ERROR;
      end
    endcase
  end

  // classification
  always_comb begin
    res_o.data  = b;
    res_o.cls   = hhlt_pkg::CLS_SEP;
    res_o.first = 1'b0;
    unique case (cur_state)
      hhlt_pkg::ST_START: begin
        if (!is_crlf) begin
          res_o.cls   = hhlt_pkg::CLS_KEY;
          res_o.first = 1'b1;
        end
      end
      hhlt_pkg::ST_KEY: begin
        if (b == hhlt_pkg::CH_COLON) begin
          res_o.cls = hhlt_pkg::CLS_SEP;
        end else if (is_crlf) begin
          res_o.cls = hhlt_pkg::CLS_ERROR;
        end else begin
          res_o.cls = hhlt_pkg::CLS_KEY;
        end
      end
      hhlt_pkg::ST_COLON: begin
        if (b != hhlt_pkg::CH_SPACE) res_o.cls = hhlt_pkg::CLS_ERROR;
      end
      hhlt_pkg::ST_SPACE: begin
        res_o.cls   = hhlt_pkg::CLS_VALUE;
        res_o.first = 1'b1;
      end
      hhlt_pkg::ST_VALUE: begin
        if (b == hhlt_pkg::CH_CR) begin
          res_o.cls = hhlt_pkg::CLS_SEP;
        end else if (over) begin
          res_o.cls = hhlt_pkg::CLS_ERROR;
        end else begin
          res_o.cls = hhlt_pkg::CLS_VALUE;
        end
      end
      hhlt_pkg::ST_CR: begin
        res_o.cls = (b == hhlt_pkg::CH_LF) ? hhlt_pkg::CLS_LINE : hhlt_pkg::CLS_ERROR;
      end
      hhlt_pkg::ST_LF: begin
        if (b != hhlt_pkg::CH_CR) begin
          res_o.cls   = hhlt_pkg::CLS_KEY;
          res_o.first = 1'b1;
        end
      end
      hhlt_pkg::ST_END_CR: begin
        res_o.cls = (b == hhlt_pkg::CH_LF) ? hhlt_pkg::CLS_END : hhlt_pkg::CLS_ERROR;
      end
      hhlt_pkg::ST_DONE: begin
        res_o.cls = hhlt_pkg::CLS_AFTER;
      end
      default: begin
        res_o.cls = hhlt_pkg::CLS_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hhlt_pkg::ST_START;
      off_q   <= '0;
      limit_q <= hhlt_pkg::LIMIT_RESET;
    end else begin
      if (adv_i) begin
        state_q <= state_d;
        off_q   <= off_d;
      end
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
    end
  end

endmodule

// ===== src/hhlt_out_stage.sv =====
// Result register: holds one classified beat until the consumer takes it.
module hhlt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pend_i,
  output logic              adv_o,
  input  hhlt_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hhlt_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  hhlt_pkg::result_t res_q;

  assign adv_o = pend_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== test/http_header_line_tokenizer_tb.sv =====
// Self-checking testbench for the HTTP header line tokenizer.
`timescale 1ns / 100ps

module http_header_line_tokenizer_tb;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_wr_en_i = 1'b0;
  logic [hhlt_pkg::LimitW-1:0] cfg_wr_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  byte_in_i = 8'h00;
  logic                        restart_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [7:0]                  byte_out_o;
  logic [2:0]                  token_class_o;
  logic                        token_first_o;

  http_header_line_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .token_class_o (token_class_o),
    .token_first_o (token_first_o)
  );

  class token_checker;
    hhlt_pkg::state_e            parse_st;
    logic [hhlt_pkg::OffW-1:0]   val_offset;
    logic [hhlt_pkg::LimitW-1:0] val_limit;
    hhlt_pkg::result_t           expected_tokens[$];
    int                          mismatches;

    function new();
      parse_st   = hhlt_pkg::ST_START;
      val_offset = '0;
      val_limit  = hhlt_pkg::LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(logic [hhlt_pkg::LimitW-1:0] v);
      val_limit = v;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void note_byte(logic [7:0] b, logic rs);
      hhlt_pkg::result_t tok;
      tok.data  = b;
      tok.cls   = hhlt_pkg::CLS_SEP;
      tok.first = 1'b0;
      if (rs) begin
        parse_st   = hhlt_pkg::ST_START;
        val_offset = '0;
      end
      case (parse_st)
        hhlt_pkg::ST_START: begin
          if (b != hhlt_pkg::CH_CR && b != hhlt_pkg::CH_LF) begin
            parse_st  = hhlt_pkg::ST_KEY;
            tok.cls   = hhlt_pkg::CLS_KEY;
            tok.first = 1'b1;
          end
        end
        hhlt_pkg::ST_KEY: begin
          if (b == hhlt_pkg::CH_COLON) begin
            parse_st = hhlt_pkg::ST_COLON;
          end else if (b == hhlt_pkg::CH_CR || b == hhlt_pkg::CH_LF) begin
            parse_st = hhlt_pkg::ST_ERROR;
            tok.cls  = hhlt_pkg::CLS_ERROR;
          end else begin
            tok.cls = hhlt_pkg::CLS_KEY;
          end
        end
        hhlt_pkg::ST_COLON: begin
          if (b == hhlt_pkg::CH_SPACE) begin
            parse_st = hhlt_pkg::ST_SPACE;
          end else begin
            parse_st = hhlt_pkg::ST_ERROR;
            tok.cls  = hhlt_pkg::CLS_ERROR;
          end
        end
        hhlt_pkg::ST_SPACE: begin
          parse_st   = hhlt_pkg::ST_VALUE;
          val_offset = '0;
          tok.cls    = hhlt_pkg::CLS_VALUE;
          tok.first  = 1'b1;
        end
        hhlt_pkg::ST_VALUE: begin
          if (val_offset != hhlt_pkg::OFFSET_MAX) val_offset = val_offset + 1'b1;
          if (b == hhlt_pkg::CH_CR) begin
            parse_st = hhlt_pkg::ST_CR;
          end else if (val_offset > val_limit) begin
            parse_st = hhlt_pkg::ST_ERROR;
            tok.cls  = hhlt_pkg::CLS_ERROR;
          end else begin
            tok.cls = hhlt_pkg::CLS_VALUE;
          end
        end
        hhlt_pkg::ST_CR: begin
          if (b == hhlt_pkg::CH_LF) begin
            parse_st = hhlt_pkg::ST_LF;
            tok.cls  = hhlt_pkg::CLS_LINE;
          end else begin
            parse_st = hhlt_pkg::ST_ERROR;
            tok.cls  = hhlt_pkg::CLS_ERROR;
          end
        end
        hhlt_pkg::ST_LF: begin
          if (b == hhlt_pkg::CH_CR) begin
            parse_st = hhlt_pkg::ST_END_CR;
          end else begin
            parse_st  = hhlt_pkg::ST_KEY;
            tok.cls   = hhlt_pkg::CLS_KEY;
            tok.first = 1'b1;
          end
        end
        hhlt_pkg::ST_END_CR: begin
          if (b == hhlt_pkg::CH_LF) begin
            parse_st = hhlt_pkg::ST_DONE;
            tok.cls  = hhlt_pkg::CLS_END;
          end else begin
            parse_st = hhlt_pkg::ST_ERROR;
            tok.cls  = hhlt_pkg::CLS_ERROR;
          end
        end
        hhlt_pkg::ST_DONE: tok.cls = hhlt_pkg::CLS_AFTER;
        default: begin
          parse_st = hhlt_pkg::ST_ERROR;
          tok.cls  = hhlt_pkg::CLS_ERROR;
        end
      endcase
      expected_tokens.push_back(tok);
    endfunction

    function void check_token(logic [7:0] b, logic [2:0] c, logic f);
      hhlt_pkg::result_t tok;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat byte=%02h class=%0d first=%0b", $time, b, c, f);
        return;
      end
      tok = expected_tokens.pop_front();
      if (b !== tok.data || c !== tok.cls || f !== tok.first) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp %02h/%0d/%0b, got %02h/%0d/%0b (byte/class/first)",
                   $time, tok.data, tok.cls, tok.first, b, c, f);
      end
    endfunction
  endclass

  token_checker      checker_h = new();
  hhlt_pkg::beat_t   stim_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) checker_h.note_byte(byte_in_i, restart_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      checker_h.check_token(byte_out_o, token_class_o, token_first_o);
  end

  // receiver: long hold-off first so the pipeline backs up, then mixed stall patterns
  initial begin
    int seg;
    int len;
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    repeat ($urandom_range(50, 80)) begin
      out_stall_i <= 1'b1;
      @(posedge clk_i);
    end
    forever begin
      seg = $urandom_range(0, 7);
      len = $urandom_range(10, 120);
      for (n = 0; n < len; n++) begin
        case (seg)
          0, 1: out_stall_i <= 1'b0;
          2, 3: out_stall_i <= ($urandom_range(0, 2) == 0);
          4:    out_stall_i <= (n % 5 == 0) || (n % 5 == 3);
          5:    out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (n < len / 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic void push_beat(logic [7:0] b, logic rs);
    hhlt_pkg::beat_t bt;
    bt.data    = b;
    bt.restart = rs;
    stim_q.push_back(bt);
  endfunction

  function automatic void push_text(string s, logic rs);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], rs && (i == 0));
  endfunction

  function automatic logic [7:0] any_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return hhlt_pkg::CH_CR;
        1:       return hhlt_pkg::CH_LF;
        2:       return hhlt_pkg::CH_COLON;
        default: return hhlt_pkg::CH_SPACE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] key_byte(bit lead);
    logic [7:0] b;
    do b = any_byte();
    while (b == hhlt_pkg::CH_CR || b == hhlt_pkg::CH_LF || (!lead && b == hhlt_pkg::CH_COLON));
    return b;
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do b = any_byte();
    while (b == hhlt_pkg::CH_CR);
    return b;
  endfunction

  // one header block: mostly well formed, some mutated, truncated or plain noise
  function automatic void build_block(int limit);
    int   kind;
    int   start;
    int   vlen;
    int   cut;
    logic rs;
    start = stim_q.size();
    kind  = $urandom_range(0, 9);
    rs    = ($urandom_range(0, 7) != 0);
    if (kind == 8) begin
      repeat ($urandom_range(1, 10)) push_beat(any_byte(), ($urandom_range(0, 15) == 0));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      push_beat($urandom_range(0, 1) ? hhlt_pkg::CH_CR : hhlt_pkg::CH_LF, rs);
      rs = 1'b0;
    end
    repeat ($urandom_range(1, 3)) begin
      push_beat(key_byte(1'b1), rs);
      rs = 1'b0;
      repeat ($urandom_range(0, 5)) push_beat(key_byte(1'b0), 1'b0);
      push_beat(hhlt_pkg::CH_COLON, 1'b0);
      push_beat(hhlt_pkg::CH_SPACE, 1'b0);
      push_beat(any_byte(), 1'b0);
      if (limit <= 20 && $urandom_range(0, 2) == 0)
        vlen = limit + $urandom_range(0, 1);
      else if (limit >= 200 && limit <= 300 && $urandom_range(0, 149) == 0)
        vlen = limit + 1;
      else
        vlen = $urandom_range(0, 8);
      repeat (vlen) push_beat(value_byte(), 1'b0);
      push_beat(hhlt_pkg::CH_CR, 1'b0);
      push_beat(hhlt_pkg::CH_LF, 1'b0);
    end
    push_beat(hhlt_pkg::CH_CR, 1'b0);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    repeat ($urandom_range(0, 2)) push_beat(any_byte(), 1'b0);
    if (kind == 6 || kind == 7)
      stim_q[start + $urandom_range(0, stim_q.size() - start - 1)].data = any_byte();
    if (kind == 9) begin
      cut = start + $urandom_range(1, stim_q.size() - start - 1);
      while (stim_q.size() > cut) void'(stim_q.pop_back());
    end
  endfunction

  task automatic send_queue(bit paced);
    int burst;
    burst = $urandom_range(1, 30);
    while (stim_q.size() > 0) begin
      in_valid_i <= 1'b1;
      byte_in_i  <= stim_q[0].data;
      restart_i  <= stim_q[0].restart;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      void'(stim_q.pop_front());
      burst--;
      if (paced && burst <= 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic write_limit(logic [hhlt_pkg::LimitW-1:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    checker_h.set_limit(v);
  endtask

  task automatic wait_drain();
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int limits[7];
    limits = '{0, 1, 4095, 255, 5, 0, 3};
    limits[5] = $urandom_range(6, 4094);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // skipped CR/LF, key byte extremes, CR and colon as value bytes, line and block end,
    // after-end bytes, colon as first key byte, LF in key, missing space
    push_beat(hhlt_pkg::CH_CR, 1'b1);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(hhlt_pkg::CH_COLON, 1'b0);
    push_beat(hhlt_pkg::CH_SPACE, 1'b0);
    push_beat(hhlt_pkg::CH_CR, 1'b0);
    push_beat(hhlt_pkg::CH_COLON, 1'b0);
    push_beat(hhlt_pkg::CH_CR, 1'b0);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_text("::", 1'b0);
    push_beat(hhlt_pkg::CH_SPACE, 1'b0);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_beat(hhlt_pkg::CH_CR, 1'b0);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_beat(hhlt_pkg::CH_CR, 1'b0);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_text("k", 1'b1);
    push_beat(hhlt_pkg::CH_LF, 1'b0);
    push_text("q", 1'b0);
    push_text("k:x", 1'b1);
    send_queue(1'b0);
    wait_drain();

    foreach (limits[p]) begin
      write_limit(limits[p][hhlt_pkg::LimitW-1:0]);
      while (stim_q.size() < 140) build_block(limits[p]);
      send_queue(1'b1);
      wait_drain();
    end

    if (checker_h.mismatches == 0 && checker_h.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
